// ----- hdl/bcw_pkg.sv -----
// Shared constants and pipeline control types for the box-corner witness test.
// No dependencies; every other file of the block imports this package.
package bcw_pkg;

  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned LANE_BITS   = 2;

  // Lane bit positions in lanes_requested and lanes_open.
  localparam int unsigned LANE_Q3 = 0;
  localparam int unsigned LANE_Q4 = 1;

  // Pipeline stage positions.
  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned STG_DIFF   = 0;
  localparam int unsigned STG_PROD   = 1;
  localparam int unsigned STG_SUM    = 2;
  localparam int unsigned STG_PART   = 3;
  localparam int unsigned STG_ACC    = 4;
  localparam int unsigned STG_OUT    = 5;

  // Load enables of the per-corner geometry stages.
  typedef struct packed {
    logic diff;
    logic prod;
    logic sum;
  } geom_en_t;

  // Load enables of the split wide multiplier.
  typedef struct packed {
    logic part;
    logic acc;
  } mul_en_t;

endpackage

// ----- hdl/bcw_req_if.sv -----
// Request channel of the box-corner witness test: four packed points and the lane request.
// Depends on bcw_pkg.
interface bcw_req_if import bcw_pkg::*; #(
  parameter int unsigned COORD_BITS = 18
);
  logic                               valid;
  logic                               ready;
  logic [NUM_AXES*COORD_BITS-1:0]     source_point;
  logic [NUM_AXES*COORD_BITS-1:0]     witness_point;
  logic [NUM_AXES*COORD_BITS-1:0]     box_low;
  logic [NUM_AXES*COORD_BITS-1:0]     box_high;
  logic [LANE_BITS-1:0]               lanes_requested;

  modport source (
    output valid, source_point, witness_point, box_low, box_high, lanes_requested,
    input  ready
  );

  modport sink (
    input  valid, source_point, witness_point, box_low, box_high, lanes_requested,
    output ready
  );
endinterface

// ----- hdl/bcw_rsp_if.sv -----
// Response channel of the box-corner witness test: the lanes that stayed open.
// Depends on bcw_pkg.
interface bcw_rsp_if import bcw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [LANE_BITS-1:0] lanes_open;

  modport source (
    output valid, lanes_open,
    input  ready
  );

  modport sink (
    input  valid, lanes_open,
    output ready
  );
endinterface

// ----- hdl/bcw_corner.sv -----
// Geometry of one box corner over three stages: differences, products, sums.
// Produces h = u.w, |u|^2 and |w|^2. Depends on bcw_pkg.
module bcw_corner import bcw_pkg::*; #(
  parameter int unsigned COORD_BITS = 18
) (
  input  logic                                         clk_i,
  input  geom_en_t                                     en_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-1:0]          src_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-1:0]          wit_i,
  input  logic [NUM_AXES-1:0][COORD_BITS-1:0]          pnt_i,
  output logic signed [2*COORD_BITS+2:0]               h_o,
  output logic [2*COORD_BITS+1:0]                      unorm_o,
  output logic [2*COORD_BITS+1:0]                      wnorm_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned NW = 2 * DW;
  localparam int unsigned HW = NW + 1;

  logic signed [DW-1:0] u_q  [NUM_AXES];
  logic signed [DW-1:0] w_q  [NUM_AXES];
  logic signed [NW-1:0] uw_d [NUM_AXES];
  logic signed [NW-1:0] uu_d [NUM_AXES];
  logic signed [NW-1:0] ww_d [NUM_AXES];
  logic signed [NW-1:0] uw_q [NUM_AXES];
  logic [NW-1:0]        uu_q [NUM_AXES];
  logic [NW-1:0]        ww_q [NUM_AXES];
  logic signed [HW-1:0] h_q;
  logic [NW-1:0]        unorm_q;
  logic [NW-1:0]        wnorm_q;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      uw_d[k] = u_q[k] * w_q[k];
      uu_d[k] = u_q[k] * u_q[k];
      ww_d[k] = w_q[k] * w_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if (en_i.diff) begin
        u_q[k] <= $signed({1'b0, wit_i[k]}) - $signed({1'b0, src_i[k]});
        w_q[k] <= $signed({1'b0, pnt_i[k]}) - $signed({1'b0, wit_i[k]});
      end
      if (en_i.prod) begin
        uw_q[k] <= uw_d[k];
        uu_q[k] <= $unsigned(uu_d[k]);
        ww_q[k] <= $unsigned(ww_d[k]);
      end
    end
    if (en_i.sum) begin
      h_q     <= HW'(uw_q[0]) + HW'(uw_q[1]) + HW'(uw_q[2]);
      unorm_q <= uu_q[0] + uu_q[1] + uu_q[2];
      wnorm_q <= ww_q[0] + ww_q[1] + ww_q[2];
    end
  end

  assign h_o     = h_q;
  assign unorm_o = unorm_q;
  assign wnorm_o = wnorm_q;

endmodule

// ----- hdl/bcw_wide_mul.sv -----
// Unsigned wide multiplier split into four half-width partial products.
// Stage one registers the partial products, stage two adds them. Depends on bcw_pkg.
module bcw_wide_mul import bcw_pkg::*; #(
  parameter int unsigned HALF_BITS = 19
) (
  input  logic                    clk_i,
  input  mul_en_t                 en_i,
  input  logic [2*HALF_BITS-1:0]  a_i,
  input  logic [2*HALF_BITS-1:0]  b_i,
  output logic [4*HALF_BITS-1:0]  p_o
);

  localparam int unsigned FW = 2 * HALF_BITS;
  localparam int unsigned PW = 4 * HALF_BITS;

  logic [HALF_BITS-1:0] a_hi, a_lo, b_hi, b_lo;
  logic [FW-1:0]        hh_q, hl_q, lh_q, ll_q;
  logic [FW:0]          mid;
  logic [PW-1:0]        p_q;

  assign {a_hi, a_lo} = a_i;
  assign {b_hi, b_lo} = b_i;

  // The cross terms share one weight, so they are added before shifting.
  assign mid = {1'b0, hl_q} + {1'b0, lh_q};

  always_ff @(posedge clk_i) begin
    if (en_i.part) begin
      hh_q <= a_hi * b_hi;
      hl_q <= a_hi * b_lo;
      lh_q <= a_lo * b_hi;
      ll_q <= a_lo * b_lo;
    end
    if (en_i.acc) begin
      p_q <= {hh_q, ll_q} + {{(HALF_BITS-1){1'b0}}, mid, {HALF_BITS{1'b0}}};
    end
  end

  assign p_o = p_q;

endmodule

// ----- hdl/box_corner_witness_predicate_top.sv -----
// Box-corner witness test, top level. Depends on bcw_pkg, bcw_req_if, bcw_rsp_if,
// bcw_corner and bcw_wide_mul. Each request transaction carries a source point a, a
// witness z and the two opposite corners of a box, each packed as three unsigned
// COORD_BITS-bit coordinates (x lowest). For all eight box corners p the block forms
// u = z - a, w = p - z, h = u.w and tests exactly, in integers, that h is positive
// and that 3*h*h and 2*h*h exceed |u x w|^2. The cross-product norm is never built
// directly: by the Lagrange identity |u x w|^2 = |u|^2*|w|^2 - h*h, so the lane q3
// test becomes 4*h*h > |u|^2*|w|^2 and the lane q4 test 3*h*h > |u|^2*|w|^2. Lane
// bits that were not requested read as zero, and a corner with h <= 0 clears both.
// The block takes one transaction per clock cycle unless every stage is full and the
// response side is not ready, and answers each with exactly one response transaction,
// in order. The six register stages are: coordinate differences, small products,
// per-corner sums, the partial products of the split wide multipliers, their
// accumulation, and the final compare and reduce into the output register. The wide
// products |u|^2*|w|^2 and h*h (up to 4*COORD_BITS+4 bits) set the depth: each runs
// as four half-width multiplies followed by an add. Every stage holds a valid bit and
// loads only when it is empty or its successor moves, so bubbles are squeezed out and
// new requests are still taken while a finished response waits on a stalled sink.
module box_corner_witness_predicate_top import bcw_pkg::*; #(
  parameter int unsigned COORD_BITS = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bcw_req_if.sink         req_i,
  bcw_rsp_if.source       rsp_o
);

  localparam int unsigned DW = COORD_BITS + 1;      // coordinate difference
  localparam int unsigned NW = 2 * DW;              // squared norms, |h|
  localparam int unsigned HW = NW + 1;              // signed h
  localparam int unsigned PW = 4 * DW;              // wide products
  localparam int unsigned CW = PW + 2;              // compare width, holds 4*h*h

  // Unpacked coordinates of the request.
  logic [NUM_AXES-1:0][COORD_BITS-1:0] src_c, wit_c, lo_c, hi_c;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] pnt_c [NUM_CORNERS];

  // Pipeline control.
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] stage_en;
  geom_en_t              geom_en;
  mul_en_t               mul_en;

  // Per-corner datapath signals.
  logic signed [HW-1:0]   h_s3     [NUM_CORNERS];
  logic [NW-1:0]          unorm_s3 [NUM_CORNERS];
  logic [NW-1:0]          wnorm_s3 [NUM_CORNERS];
  logic [NW-1:0]          hmag_s3  [NUM_CORNERS];
  logic [PW-1:0]          uw_s5    [NUM_CORNERS];
  logic [PW-1:0]          h2_s5    [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] hpos_s3;
  logic [NUM_CORNERS-1:0] hpos_s4_q, hpos_s5_q;
  logic [NUM_CORNERS-1:0] q3_ok, q4_ok;

  // Lane requests travel alongside the data up to the output stage.
  logic [LANE_BITS-1:0] lanes_q [STG_OUT];
  logic [LANE_BITS-1:0] lanes_open_d, lanes_open_q;

  assign src_c = req_i.source_point;
  assign wit_c = req_i.witness_point;
  assign lo_c  = req_i.box_low;
  assign hi_c  = req_i.box_high;

  // A stage loads when it is empty or when the next stage takes its contents.
  always_comb begin
    stage_en[STG_OUT] = !valid_q[STG_OUT] || rsp_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign geom_en.diff = stage_en[STG_DIFF];
  assign geom_en.prod = stage_en[STG_PROD];
  assign geom_en.sum  = stage_en[STG_SUM];
  assign mul_en.part  = stage_en[STG_PART];
  assign mul_en.acc   = stage_en[STG_ACC];

  assign req_i.ready = stage_en[STG_DIFF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[STG_DIFF]) begin
        valid_q[STG_DIFF] <= req_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Eight corner datapaths. Bit k of the corner number picks the upper bound on axis k.
  for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
    localparam logic [NUM_AXES-1:0] CSel = NUM_AXES'(c);

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
      assign pnt_c[c][k] = CSel[k] ? hi_c[k] : lo_c[k];
    end

    bcw_corner #(
      .COORD_BITS (COORD_BITS)
    ) u_corner (
      .clk_i   (clk_i),
      .en_i    (geom_en),
      .src_i   (src_c),
      .wit_i   (wit_c),
      .pnt_i   (pnt_c[c]),
      .h_o     (h_s3[c]),
      .unorm_o (unorm_s3[c]),
      .wnorm_o (wnorm_s3[c])
    );

    // When h is positive it is below 3 * 2^(2*COORD_BITS), so its low NW bits are exact.
    assign hpos_s3[c] = !h_s3[c][HW-1] && (h_s3[c] != '0);
    assign hmag_s3[c] = h_s3[c][NW-1:0];

    bcw_wide_mul #(
      .HALF_BITS (DW)
    ) u_mul_uw (
      .clk_i (clk_i),
      .en_i  (mul_en),
      .a_i   (unorm_s3[c]),
      .b_i   (wnorm_s3[c]),
      .p_o   (uw_s5[c])
    );

    bcw_wide_mul #(
      .HALF_BITS (DW)
    ) u_mul_hh (
      .clk_i (clk_i),
      .en_i  (mul_en),
      .a_i   (hmag_s3[c]),
      .b_i   (hmag_s3[c]),
      .p_o   (h2_s5[c])
    );

    // Lane q3: 4*h*h > |u|^2*|w|^2.  Lane q4: 3*h*h > |u|^2*|w|^2.
    assign q3_ok[c] = {h2_s5[c], 2'b00} > CW'(uw_s5[c]);
    assign q4_ok[c] = (CW'({h2_s5[c], 1'b0}) + CW'(h2_s5[c])) > CW'(uw_s5[c]);
  end

  always_comb begin
    lanes_open_d          = '0;
    lanes_open_d[LANE_Q3] = lanes_q[STG_ACC][LANE_Q3] & (&hpos_s5_q) & (&q3_ok);
    lanes_open_d[LANE_Q4] = lanes_q[STG_ACC][LANE_Q4] & (&hpos_s5_q) & (&q4_ok);
  end

  // Sideband payload registers: lane requests, sign flags and the result.
  always_ff @(posedge clk_i) begin
    if (stage_en[STG_DIFF]) begin
      lanes_q[STG_DIFF] <= req_i.lanes_requested;
    end
    for (int k = 1; k < STG_OUT; k++) begin
      if (stage_en[k]) begin
        lanes_q[k] <= lanes_q[k-1];
      end
    end
    if (stage_en[STG_PART]) begin
      hpos_s4_q <= hpos_s3;
    end
    if (stage_en[STG_ACC]) begin
      hpos_s5_q <= hpos_s4_q;
    end
    if (stage_en[STG_OUT]) begin
      lanes_open_q <= lanes_open_d;
    end
  end

  assign rsp_o.valid      = valid_q[STG_OUT];
  assign rsp_o.lanes_open = lanes_open_q;

  // A completely full pipeline facing a stalled sink must refuse new requests.
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((&valid_q) && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while the full pipeline is stalled");

  // A response only appears after an item sat in the accumulate stage.
  a_rsp_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(rsp_o.valid) |-> $past(valid_q[STG_ACC]))
    else $error("response valid without an item behind it");

  // A corner with non-positive h closes every lane.
  a_nonpos_h : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (valid_q[STG_ACC] && stage_en[STG_OUT] && !(&hpos_s5_q)) |=> (lanes_open_q == '0))
    else $error("lane open although some corner has h <= 0");

  // Open lanes are always a subset of the requested lanes.
  a_lane_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (valid_q[STG_ACC] && stage_en[STG_OUT])
      |=> ((lanes_open_q & ~$past(lanes_q[STG_ACC])) == '0))
    else $error("lane open that was not requested");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for box_corner_witness_predicate_top: directed and random requests
// are checked against an exact integer predictor. Depends on bcw_pkg, bcw_req_if, bcw_rsp_if.
module tb_top;
  import bcw_pkg::*;

  localparam int unsigned COORD_W = 18;
  localparam longint      COORD_MAX = (longint'(1) << COORD_W) - 1;
  localparam longint      COORD_MID = longint'(1) << (COORD_W - 1);

  typedef logic [NUM_AXES*COORD_W-1:0] point_t;
  typedef logic [LANE_BITS-1:0]        lanes_t;

  // One outstanding response: the request number and the lanes it should report.
  typedef struct {
    int unsigned seq;
    lanes_t      lanes;
  } lanes_due_t;

  // Ways the response side can hold off the block.
  typedef enum int unsigned {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_CHOKED
  } sink_mode_e;

  logic clk_i;
  logic rst_ni;

  bcw_req_if #(.COORD_BITS(COORD_W)) req_if ();
  bcw_rsp_if                         rsp_if ();

  box_corner_witness_predicate_top #(
    .COORD_BITS(COORD_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Responses come back in request order, so a plain FIFO of predictions is enough.
  lanes_due_t  lanes_due_q[$];
  int unsigned mismatch_count = 0;
  int unsigned requests_sent  = 0;
  int unsigned burst_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Every corner is tested on its own: u = z - a, w = p - z, h = u.w
  // and xi = |u x w|^2. The cross product is formed directly (not through the
  // Lagrange identity that the block uses), so the two paths are independent.
  // Coordinate differences fit in 19 signed bits, h and the cross terms well
  // inside 64 bits; the squares go to 128 bits so no compare can wrap.
  // ---------------------------------------------------------------------------
  function automatic longint axis_value(input point_t p, input int unsigned ax);
    return longint'(p[ax*COORD_W +: COORD_W]);
  endfunction

  function automatic lanes_t lanes_through_box(input point_t src, input point_t wit,
                                               input point_t lo, input point_t hi,
                                               input lanes_t requested);
    lanes_t              lanes;
    longint              u [NUM_AXES];
    longint              w [NUM_AXES];
    longint              h;
    longint              zc;
    longint              pc;
    longint              cross_term;
    logic signed [127:0] xi;
    logic signed [127:0] h_sq;
    logic signed [127:0] cross_w;
    int unsigned         j;
    int unsigned         k;
    lanes = requested;
    // Once nothing is requested (or every lane has closed) the answer is fixed.
    for (int unsigned corner = 0; corner < NUM_CORNERS && lanes != '0; corner++) begin
      h = 0;
      for (int unsigned ax = 0; ax < NUM_AXES; ax++) begin
        zc    = axis_value(wit, ax);
        // A set bit of the corner number picks the upper bound on that axis.
        pc    = corner[ax] ? axis_value(hi, ax) : axis_value(lo, ax);
        u[ax] = zc - axis_value(src, ax);
        w[ax] = pc - zc;
        h    += u[ax] * w[ax];
      end
      // A corner at or behind the plane through z closes both lanes outright.
      if (h <= 0) begin
        lanes = '0;
        break;
      end
      xi = '0;
      for (int unsigned ax = 0; ax < NUM_AXES; ax++) begin
        j          = (ax + 1) % NUM_AXES;
        k          = (ax + 2) % NUM_AXES;
        cross_term = u[j] * w[k] - u[k] * w[j];
        cross_w    = cross_term;
        xi        += cross_w * cross_w;
      end
      h_sq = h;
      h_sq = h_sq * h_sq;
      if (!(3 * h_sq > xi)) lanes[LANE_Q3] = 1'b0;
      if (!(2 * h_sq > xi)) lanes[LANE_Q4] = 1'b0;
    end
    return lanes;
  endfunction

  // ---------------------------------------------------------------------------
  // Small helpers for building points.
  // ---------------------------------------------------------------------------
  function automatic point_t pack_point(input longint x, input longint y, input longint z);
    return {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
  endfunction

  function automatic point_t random_point();
    return point_t'({$urandom, $urandom});
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Requests go out in bursts of random length; between bursts
  // valid drops for a random gap, and about a third of the bursts follow the
  // previous one with no gap at all, so long back-to-back stretches happen too.
  // valid gets a single nonblocking update per time step: it is lowered at the
  // edge that accepted the previous transaction and raised on a later edge.
  // The prediction is queued at the edge where the transaction is accepted.
  // ---------------------------------------------------------------------------
  task automatic send_request(input point_t src, input point_t wit, input point_t lo,
                              input point_t hi, input lanes_t requested);
    int unsigned gap;
    lanes_due_t  due;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.source_point    <= src;
    req_if.witness_point   <= wit;
    req_if.box_low         <= lo;
    req_if.box_high        <= hi;
    req_if.lanes_requested <= requested;
    req_if.valid           <= 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    due.seq     = requests_sent;
    due.lanes   = lanes_through_box(src, wit, lo, hi, requested);
    lanes_due_q = {lanes_due_q, due};
    requests_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Response side: ready follows a mode drawn at random for each stretch of random length:
  // always ready, random, a rotating 8-bit mask, or heavy back-pressure.
  // ---------------------------------------------------------------------------
  initial begin : sink_stall_pattern
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned phase;
    logic [7:0]  mask;
    mode      = SINK_OPEN;
    mode_left = 0;
    phase     = 0;
    mask      = '1;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
        mask      = 8'($urandom);
      end
      mode_left--;
      phase++;
      case (mode)
        SINK_OPEN: begin
          rsp_if.ready <= 1'b1;
        end
        SINK_RANDOM: begin
          rsp_if.ready <= ($urandom_range(0, 3) != 0);
        end
        SINK_PATTERN: begin
          rsp_if.ready <= mask[phase % 8];
        end
        default: begin
          rsp_if.ready <= ($urandom_range(0, 9) == 0);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker. Every accepted response transaction is matched against the oldest
  // prediction. Only the first ten mismatches are described; all are counted.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input int unsigned seq, input lanes_t want, input lanes_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] lanes_open mismatch on request %0d: expected %b, got %b",
               $realtime, seq, want, got);
    end
  endtask

  always @(posedge clk_i) begin : lanes_check
    lanes_due_t due;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (lanes_due_q.size() == 0) begin
        // A response with nothing outstanding.
        note_mismatch(requests_sent, 'x, rsp_if.lanes_open);
      end else begin
        due = lanes_due_q.pop_front();
        if (rsp_if.lanes_open !== due.lanes) note_mismatch(due.seq, due.lanes, rsp_if.lanes_open);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Every lane request against a geometry that passes both lanes, then a
  // geometry that passes only q3, then the exact q4 boundary (xi == 2*h*h).
  task automatic test_lane_requests();
    point_t a;
    point_t z;
    a = pack_point(0, 0, 0);
    z = pack_point(1000, 1000, 1000);
    for (int r = 0; r < 4; r++) begin
      send_request(a, z, pack_point(200000, 200000, 200000),
                   pack_point(200100, 200100, 200100), lanes_t'(r));
    end
    // Angle between 54.7 and 60 degrees: tan^2 = 2.25, so q3 holds and q4 fails.
    a = pack_point(900, 1000, 1000);
    send_request(a, z, pack_point(1100, 1150, 1000), pack_point(1100, 1150, 1000), '1);
    send_request(a, z, pack_point(1100, 1150, 1000), pack_point(1100, 1150, 1000),
                 lanes_t'(1 << LANE_Q3));
    send_request(a, z, pack_point(1100, 1150, 1000), pack_point(1100, 1150, 1000),
                 lanes_t'(1 << LANE_Q4));
    // u = (1,0,0), w = (1,1,1): xi equals 2*h*h exactly, so q4 must close.
    send_request(pack_point(10, 10, 10), pack_point(11, 10, 10),
                 pack_point(12, 11, 11), pack_point(12, 11, 11), '1);
  endtask

  // h of zero or below: at a right angle, with the witness on the source, and
  // at a single corner of an otherwise good box.
  task automatic test_nonpositive_h();
    send_request(pack_point(10, 10, 10), pack_point(11, 10, 10),
                 pack_point(11, 11, 10), pack_point(11, 11, 10), '1);
    send_request(pack_point(500, 600, 700), pack_point(500, 600, 700),
                 pack_point(800, 900, 1000), pack_point(900, 1000, 1100), '1);
    send_request(pack_point(0, 0, 0), pack_point(1000, 1000, 1000),
                 pack_point(0, 1001, 1001), pack_point(5000, 5000, 5000), '1);
  endtask

  // Field extremes and the largest products the coordinate width allows.
  task automatic test_extremes();
    send_request('0, '0, '0, '0, '1);
    send_request('1, '1, '1, '1, '1);
    send_request(pack_point(0, 0, 0), pack_point(1, 1, 1), '1, '1, '1);
    send_request(pack_point(0, 0, 0), pack_point(COORD_MID, COORD_MID, COORD_MID),
                 pack_point(COORD_MID + 1, COORD_MID + 1, COORD_MID + 1), '1, '1);
    send_request('1, pack_point(COORD_MID, COORD_MID, COORD_MID), '0,
                 pack_point(COORD_MID - 1, COORD_MID - 1, COORD_MID - 1), '1);
    send_request(pack_point(0, COORD_MAX, 0), pack_point(COORD_MID, COORD_MID, COORD_MID),
                 pack_point(COORD_MAX, 0, COORD_MAX), pack_point(COORD_MAX, 0, COORD_MAX), '1);
  endtask

  // Boxes whose bounds are swapped on every axis or on some axes only.
  task automatic test_inverted_box();
    send_request(pack_point(0, 0, 0), pack_point(COORD_MID, COORD_MID, COORD_MID), '1,
                 pack_point(COORD_MID + 1, COORD_MID + 1, COORD_MID + 1), '1);
    send_request(pack_point(0, 0, 0), pack_point(1000, 1000, 1000),
                 pack_point(200100, 200100, 200100), pack_point(200000, 200000, 200000), '1);
    send_request(pack_point(0, 0, 0), pack_point(1000, 1000, 1000),
                 pack_point(200100, 200000, 200000), pack_point(200000, 200100, 200100), '1);
  endtask

  // ---------------------------------------------------------------------------
  // Random test. Fully random points almost always put some corner behind the
  // witness, so most requests are built to be interesting: a random witness, a
  // source a random step behind it, and a box centered some steps further along
  // the same direction with a random spread. That gives angles on both sides of
  // both lane thresholds. One request in five is plain noise, and one shaped
  // request in eight has a box that is inverted on one axis.
  // ---------------------------------------------------------------------------
  task automatic test_random_witnesses(input int unsigned count);
    longint      ac [NUM_AXES];
    longint      zc [NUM_AXES];
    longint      lc [NUM_AXES];
    longint      hc [NUM_AXES];
    longint      dir;
    longint      center;
    longint      spread;
    longint      swap;
    int unsigned scale;
    int unsigned reach;
    int unsigned flip_axis;
    lanes_t      requested;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_request(random_point(), random_point(), random_point(), random_point(),
                     lanes_t'($urandom_range(0, 3)));
      end else begin
        requested = ($urandom_range(0, 3) == 0) ? lanes_t'($urandom_range(0, 2)) : '1;
        scale     = $urandom_range(1, COORD_W - 2);
        reach     = $urandom_range(1, 6);
        for (int unsigned ax = 0; ax < NUM_AXES; ax++) begin
          zc[ax] = $urandom_range(0, COORD_MAX);
          dir    = longint'($urandom_range(0, 32'd1 << (scale + 1))) - (longint'(1) << scale);
          ac[ax] = clamp_coord(zc[ax] - dir);
          dir    = zc[ax] - ac[ax];
          center = clamp_coord(zc[ax] + reach * dir);
          spread = $urandom_range(0, 32'd1 << $urandom_range(0, scale));
          lc[ax] = clamp_coord(center - spread);
          hc[ax] = clamp_coord(center + spread);
        end
        if ($urandom_range(0, 7) == 0) begin
          flip_axis     = $urandom_range(0, NUM_AXES - 1);
          swap          = lc[flip_axis];
          lc[flip_axis] = hc[flip_axis];
          hc[flip_axis] = swap;
        end
        send_request(pack_point(ac[0], ac[1], ac[2]), pack_point(zc[0], zc[1], zc[2]),
                     pack_point(lc[0], lc[1], lc[2]), pack_point(hc[0], hc[1], hc[2]),
                     requested);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence: reset, directed tests, random test, then drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                 <= 1'b0;
    req_if.valid           <= 1'b0;
    req_if.source_point    <= '0;
    req_if.witness_point   <= '0;
    req_if.box_low         <= '0;
    req_if.box_high        <= '0;
    req_if.lanes_requested <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lane_requests();
    test_nonpositive_h();
    test_extremes();
    test_inverted_box();
    test_random_witnesses(450);

    req_if.valid <= 1'b0;
    // Wait for every outstanding transaction; if one never comes, the watchdog
    // below ends the run. The extra cycles catch any stray late response.
    while (lanes_due_q.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_STAGES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every response held off by
  // the heaviest back-pressure and every request behind its longest gap).
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
